// ===== hw/rtl/mrb_pkg.sv =====
// Shared constants, types and command codes of the modal resonator bank.
package mrb_pkg;

    // Bank size and field widths
    localparam int MAX_MODES = 32;
    localparam int ADDR_W    = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int CNT_W     = $clog2(MAX_MODES + 1);
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 5;
    localparam int COEF_W    = 32;
    localparam int GAIN_W    = 32;
    localparam int DRIVE_W   = 24;
    localparam int HIST_W    = 40;
    localparam int OUT_W     = 32;
    localparam int ACT_W     = 6;
    localparam int ACC_W     = HIST_W + CNT_W;
    localparam int COEF_SET_W = 2 * COEF_W + GAIN_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic signed [HIST_W-1:0] t_hist;

    // One mode's coefficient set as held in the coefficient memory
    typedef struct packed {
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] b2;
        logic [GAIN_W-1:0]        gain;
    } t_coef_set;

    // Tag that travels with a mode through the MAC pipeline
    typedef struct packed {
        logic  vld;
        t_addr idx;
    } t_tag;

endpackage

// ===== hw/rtl/mrb_if.sv =====
// Input and output channel interfaces of the modal resonator bank.
interface mrb_in_if
    import mrb_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [IDX_W-1:0]          mode_index;
    logic signed [COEF_W-1:0]  pole_coef_a1;
    logic signed [COEF_W-1:0]  pole_coef_b2;
    logic [GAIN_W-1:0]         mode_gain;
    logic signed [DRIVE_W-1:0] drive_sample;

    modport source (
        output valid, command, mode_index, pole_coef_a1, pole_coef_b2, mode_gain,
               drive_sample,
        input  ready
    );
    modport sink (
        input  valid, command, mode_index, pole_coef_a1, pole_coef_b2, mode_gain,
               drive_sample,
        output ready
    );
endinterface

interface mrb_out_if
    import mrb_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] out_sample;
    logic                    clipped;

    modport source (
        output valid, out_sample, clipped,
        input  ready
    );
    modport sink (
        input  valid, out_sample, clipped,
        output ready
    );
endinterface

// ===== hw/rtl/mrb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/mrb_mac.sv =====
// Shared resonator MAC: three products, floor shifts, sum and history saturation.
module mrb_mac
    import mrb_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_tag                      i_tag,
    input  t_coef_set                 i_coef,
    input  t_hist                     i_h1,
    input  t_hist                     i_h2,
    input  logic signed [DRIVE_W-1:0] i_drive,
    output t_tag                      o_tag,
    output t_hist                     o_y,
    output t_hist                     o_h1,
    output logic                      o_busy
);
    localparam int HALF_W  = HIST_W / 2;
    localparam int HI_W    = HIST_W - HALF_W;
    localparam int PH_W    = COEF_W + HI_W;
    localparam int PL_W    = COEF_W + HALF_W + 1;
    localparam int PG_W    = DRIVE_W + GAIN_W + 1;
    localparam int FULL_W  = COEF_W + HIST_W;
    localparam int TERM_W  = FULL_W - 30;
    localparam int SUM_W   = TERM_W + 2;

    // Stage A: partial products
    t_tag                     r_pa_tag;
    t_hist                    r_pa_h1;
    logic signed [PH_W-1:0]   r_a1_hi;
    logic signed [PL_W-1:0]   r_a1_lo;
    logic signed [PH_W-1:0]   r_b2_hi;
    logic signed [PL_W-1:0]   r_b2_lo;
    logic signed [PG_W-1:0]   r_drv;

    // Stage B: Q10.32 terms
    t_tag                     r_pb_tag;
    t_hist                    r_pb_h1;
    logic signed [TERM_W-1:0] r_t_a1;
    logic signed [TERM_W-1:0] r_t_b2;
    logic signed [TERM_W-1:0] r_t_drv;

    logic signed [FULL_W-1:0] w_full_a1;
    logic signed [FULL_W-1:0] w_full_b2;
    logic signed [SUM_W-1:0]  w_sum;
    logic                     w_pos_ovf;
    logic                     w_neg_ovf;

    // Split each history into a signed high half and an unsigned low half
    always_ff @(posedge i_clk) begin
        r_a1_hi <= $signed(i_coef.a1) * $signed(i_h1[HIST_W-1:HALF_W]);
        r_a1_lo <= $signed(i_coef.a1) * $signed({1'b0, i_h1[HALF_W-1:0]});
        r_b2_hi <= $signed(i_coef.b2) * $signed(i_h2[HIST_W-1:HALF_W]);
        r_b2_lo <= $signed(i_coef.b2) * $signed({1'b0, i_h2[HALF_W-1:0]});
        r_drv   <= $signed(i_drive) * $signed({1'b0, i_coef.gain});
        r_pa_h1 <= i_h1;
    end

    // Recombine exact products; the floor shift is a plain bit-select
    assign w_full_a1 = (FULL_W'(r_a1_hi) <<< HALF_W) + FULL_W'(r_a1_lo);
    assign w_full_b2 = (FULL_W'(r_b2_hi) <<< HALF_W) + FULL_W'(r_b2_lo);

    always_ff @(posedge i_clk) begin
        r_t_a1  <= w_full_a1[FULL_W-1:30];
        r_t_b2  <= w_full_b2[FULL_W-1:30];
        r_t_drv <= TERM_W'($signed(r_drv[PG_W-1:18]));
        r_pb_h1 <= r_pa_h1;
    end

    // Advance the tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa_tag <= '0;
            r_pb_tag <= '0;
        end else begin
            r_pa_tag <= i_tag;
            r_pb_tag <= r_pa_tag;
        end
    end

    // Sum the terms and saturate to the history width
    assign w_sum     = SUM_W'(r_t_a1) + SUM_W'(r_t_b2) + SUM_W'(r_t_drv);
    assign w_pos_ovf = !w_sum[SUM_W-1] && (|w_sum[SUM_W-2:HIST_W-1]);
    assign w_neg_ovf = w_sum[SUM_W-1] && !(&w_sum[SUM_W-2:HIST_W-1]);

    always_comb begin
        if (w_pos_ovf) begin
            o_y = {1'b0, {(HIST_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            o_y = {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            o_y = w_sum[HIST_W-1:0];
        end
    end

    assign o_tag  = r_pb_tag;
    assign o_h1   = r_pb_h1;
    assign o_busy = r_pa_tag.vld || r_pb_tag.vld;
endmodule

// ===== hw/rtl/modal_resonator_bank.sv =====
// Modal resonator bank: sequencer, history and coefficient memories, accumulator.
// A process transaction with n active modes issues one mode per cycle through the
// shared MAC, driven by an issue counter over the single read port of each memory.
// Input is taken only in the idle state: load and clear complete there, while a process
// is not followed by the next transaction until its result is in the output register.
// Reset: active_modes = 1, all histories read as zero through per-entry valid bits,
// coefficients undefined until loaded; no clearing pass is needed.
module modal_resonator_bank
    import mrb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    mrb_in_if.sink           i_in,
    mrb_out_if.source        o_out,
    input  logic             i_cfg_we,
    input  logic [ACT_W-1:0] i_cfg_wdata
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [ACT_W-1:0]          r_active;
    logic [MAX_MODES-1:0]      r_hist_vld;
    logic signed [DRIVE_W-1:0] r_drive;
    t_cnt                      r_nmodes;
    t_cnt                      r_issue;
    t_tag                      r_p1;
    logic                      r_p1_hvld;
    t_hist                     r_y;
    logic                      r_y_vld;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_out_vld;
    logic signed [OUT_W-1:0]   r_out_sample;
    logic                      r_out_clip;

    logic                      w_accept;
    logic                      w_issue;
    t_addr                     w_raddr;
    logic                      w_coef_we;
    t_coef_set                 w_coef_wdata;
    t_coef_set                 w_coef_rdata;
    logic [2*HIST_W-1:0]       w_hist_rdata;
    t_hist                     w_h1;
    t_hist                     w_h2;
    t_tag                      w_mac_tag;
    t_hist                     w_mac_y;
    t_hist                     w_mac_h1;
    logic                      w_mac_busy;
    logic signed [ACC_W-1:0]   w_shift;
    logic                      w_pos_ovf;
    logic                      w_neg_ovf;
    logic                      w_drained;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_issue    = (r_state == S_RUN) && (r_issue < r_nmodes);
    assign w_raddr    = r_issue[ADDR_W-1:0];

    // Coefficient memory: loaded by command, read by the sequencer
    assign w_coef_we = w_accept && (i_in.command == CMD_LOAD)
                       && (int'(i_in.mode_index) < MAX_MODES);
    assign w_coef_wdata.a1   = i_in.pole_coef_a1;
    assign w_coef_wdata.b2   = i_in.pole_coef_b2;
    assign w_coef_wdata.gain = i_in.mode_gain;

    mrb_ram #(
        .WIDTH (COEF_SET_W),
        .DEPTH (MAX_MODES)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (ADDR_W'(i_in.mode_index)),
        .i_wdata (w_coef_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_coef_rdata)
    );

    // History memory: {history one, history two} per mode, written back by the MAC
    mrb_ram #(
        .WIDTH (2 * HIST_W),
        .DEPTH (MAX_MODES)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_mac_tag.vld),
        .i_waddr (w_mac_tag.idx),
        .i_wdata ({w_mac_y, w_mac_h1}),
        .i_raddr (w_raddr),
        .o_rdata (w_hist_rdata)
    );

    // Entries never written since reset or clear read as zero
    assign w_h1 = r_p1_hvld ? w_hist_rdata[2*HIST_W-1:HIST_W] : '0;
    assign w_h2 = r_p1_hvld ? w_hist_rdata[HIST_W-1:0] : '0;

    mrb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_p1),
        .i_coef  (w_coef_rdata),
        .i_h1    (w_h1),
        .i_h2    (w_h2),
        .i_drive (r_drive),
        .o_tag   (w_mac_tag),
        .o_y     (w_mac_y),
        .o_h1    (w_mac_h1),
        .o_busy  (w_mac_busy)
    );

    assign w_drained = !w_issue && !r_p1.vld && !w_mac_busy && !r_y_vld;

    // Narrow the accumulated sum to Q8.24 and saturate
    assign w_shift   = r_acc >>> 8;
    assign w_pos_ovf = !w_shift[ACC_W-1] && (|w_shift[ACC_W-2:OUT_W-1]);
    assign w_neg_ovf = w_shift[ACC_W-1] && !(&w_shift[ACC_W-2:OUT_W-1]);

    // Payload registers of the datapath
    always_ff @(posedge i_clk) begin
        r_p1_hvld <= r_hist_vld[w_raddr];
        r_y       <= w_mac_y;
        if (w_accept) begin
            r_drive  <= i_in.drive_sample;
            r_nmodes <= (int'(r_active) > MAX_MODES) ? CNT_W'(MAX_MODES)
                                                      : CNT_W'(r_active);
        end
    end

    // Sequencer, valid bits, accumulator and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_active     <= ACT_W'(1);
            r_hist_vld   <= '0;
            r_issue      <= '0;
            r_p1         <= '0;
            r_y_vld      <= 1'b0;
            r_acc        <= '0;
            r_out_vld    <= 1'b0;
            r_out_sample <= '0;
            r_out_clip   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end

            // Issue one mode per cycle
            r_p1.vld <= w_issue;
            r_p1.idx <= w_raddr;
            if (w_issue) begin
                r_issue <= r_issue + CNT_W'(1);
            end

            // Mark written-back entries, accumulate mode outputs
            if (w_mac_tag.vld) begin
                r_hist_vld[w_mac_tag.idx] <= 1'b1;
            end
            r_y_vld <= w_mac_tag.vld;
            if (r_y_vld) begin
                r_acc <= r_acc + ACC_W'(r_y);
            end

            // Drop the result once taken
            if (o_out.ready && (r_state != S_DONE)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.command)
                            CMD_PROCESS: begin
                                r_issue <= '0;
                                r_acc   <= '0;
                                r_state <= S_RUN;
                            end
                            CMD_CLEAR: begin
                                r_hist_vld <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    if (w_drained) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out_vld <= 1'b1;
                        if (w_pos_ovf) begin
                            r_out_sample <= {1'b0, {(OUT_W-1){1'b1}}};
                            r_out_clip   <= 1'b1;
                        end else if (w_neg_ovf) begin
                            r_out_sample <= {1'b1, {(OUT_W-1){1'b0}}};
                            r_out_clip   <= 1'b1;
                        end else begin
                            r_out_sample <= w_shift[OUT_W-1:0];
                            r_out_clip   <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_sample = r_out_sample;
    assign o_out.clipped    = r_out_clip;

    // Write-back only touches modes inside the active range
    a_wb_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_tag.vld |-> (CNT_W'(w_mac_tag.idx) < r_nmodes))
        else $error("history write-back outside active modes");

    // New transactions are taken only with an empty pipeline
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!r_p1.vld && !w_mac_busy && !r_y_vld))
        else $error("input ready while MAC pipeline busy");

    // A clear empties every history
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.command == CMD_CLEAR)) |=> (r_hist_vld == '0))
        else $error("histories not cleared");

    // A result appears only out of the final state
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == S_DONE))
        else $error("result produced outside the done state");
endmodule
